### hw/rtl/wkm_pkg.sv
package wkm_pkg;

  localparam int unsigned SumW = 36;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeStart = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] population;
    logic [15:0] position;
  } wkm_in_t;

  typedef struct packed {
    logic [3:0]      site_index;
    logic [SumW-1:0] best_sum;
    logic            no_solution;
    logic            last;
  } wkm_out_t;

endpackage

### hw/rtl/wkm_city_mem.sv
module wkm_city_mem import wkm_pkg::*; #(
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/weighted_k_median_line_search.sv
// Weighted k-median search over cities on a line.
// The input channel carries beats of type wkm_in_t. A load beat (mode 0)
// stores one city in the city memory; beats beyond the memory depth are
// dropped. A start beat (mode 1) runs the exhaustive search over every
// ascending k-subset of the loaded cities and clears the city count.
// k comes from the configuration register (reset value 1), written through
// cfg_we_i/cfg_wdata_i while the block is idle; the user is bound to that,
// as the block itself does not enforce it. The search is sequenced through
// the one read port of the city memory: per subset and per city, StCity
// and StCwait read the city, StSite and StSwait read and compare each site
// until the distance grows again, and StAcc, StMul and StNext weigh, add
// and advance. Results then leave as k beats of type wkm_out_t, the last
// one flagged; an invalid k gives one beat with no_solution set.
// The output register holds its beat while out_stall_i is high, and the
// block takes no input beat until the results are all gone.
// Reset clears the city count, the sequencer and the output valid; the
// memory contents are undefined until loaded.
module weighted_k_median_line_search import wkm_pkg::*; #(
  parameter int unsigned MAX_CITIES = 16,
  parameter int unsigned MAX_SITES  = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wkm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wkm_out_t out_data_o
);

  localparam int unsigned AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int unsigned CW = $clog2(MAX_CITIES + 1);
  localparam int unsigned SW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int unsigned KW = $clog2(MAX_SITES + 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCity  = 4'd1;
  localparam logic [3:0] StCwait = 4'd2;
  localparam logic [3:0] StSite  = 4'd3;
  localparam logic [3:0] StSwait = 4'd4;
  localparam logic [3:0] StAcc   = 4'd5;
  localparam logic [3:0] StMul   = 4'd6;
  localparam logic [3:0] StNext  = 4'd7;
  localparam logic [3:0] StEmit  = 4'd8;
  localparam logic [3:0] StFail  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [3:0]    k_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] n_q;
  logic [KW-1:0] kk_q;
  logic [AW-1:0] cur_q  [MAX_SITES];
  logic [AW-1:0] best_q [MAX_SITES];
  logic [SumW:0] best_sum_q;
  logic [SumW:0] total_q;
  logic [AW-1:0] city_q;
  logic [15:0]   cpos_q, cpop_q;
  logic [SW-1:0] j_q;
  logic [16:0]   near_q, prev_q;
  logic [31:0]   prod_q;
  logic [SW-1:0] emit_q;
  logic          ovalid_q;
  wkm_out_t      odata_q;

  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;
  logic          accept;

  assign accept     = in_valid_i && (state_q == StIdle) && !ovalid_q;
  assign in_stall_o = (state_q != StIdle) || ovalid_q;
  assign mem_we     = accept && (in_data_i.mode == ModeLoad)
                      && (count_q < CW'(MAX_CITIES));

  always_comb begin
    mem_raddr = city_q;
    if (state_q == StSite) begin
      mem_raddr = cur_q[j_q];
    end
  end

  wkm_city_mem #(.AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({in_data_i.population, in_data_i.position}),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  logic [16:0] site_dist;
  assign site_dist = (mem_rdata[15:0] >= cpos_q) ? 17'(mem_rdata[15:0] - cpos_q)
                                                 : 17'(cpos_q - mem_rdata[15:0]);

  // Subset advance: find rightmost index that can still grow.
  logic          adv_ok;
  logic [AW-1:0] nxt [MAX_SITES];
  always_comb begin
    logic found;
    logic [AW:0] lim;
    found  = 1'b0;
    adv_ok = 1'b0;
    for (int i = 0; i < MAX_SITES; i++) nxt[i] = cur_q[i];
    for (int i = MAX_SITES - 1; i >= 0; i--) begin
      lim = (AW+1)'(n_q) - (AW+1)'(kk_q) + (AW+1)'(i);
      if (!found && (KW'(i) < kk_q) && ((AW+1)'(cur_q[i]) < lim)) begin
        found  = 1'b1;
        adv_ok = 1'b1;
        nxt[i] = cur_q[i] + 1'b1;
        for (int m = i + 1; m < MAX_SITES; m++) nxt[m] = nxt[i] + AW'(m - i);
      end
    end
  end

  logic [SumW:0] tsum;
  assign tsum = total_q + (SumW+1)'(prod_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept && in_data_i.mode == ModeStart) begin
        if (k_q == 4'd0 || 32'(k_q) > MAX_SITES || CW'(k_q) > count_q)
          state_d = StFail;
        else
          state_d = StCity;
      end
      StCity:  state_d = StCwait;
      StCwait: state_d = StSite;
      StSite:  state_d = StSwait;
      StSwait: state_d = StSite;
      StAcc:   state_d = StMul;
      StMul:   state_d = StNext;
      StNext:  state_d = StCity;
      StEmit:  if (!ovalid_q || !out_stall_i)
                 if (KW'(emit_q) + 1'b1 == kk_q) state_d = StIdle;
      StFail:  if (!ovalid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (state_q == StSwait) begin
      if ((KW'(j_q) + 1'b1 == kk_q) || (j_q != '0 && site_dist > prev_q))
        state_d = StAcc;
    end
    if (state_q == StNext) begin
      if ((CW'(city_q) + 1'b1) == n_q && !adv_ok) state_d = StEmit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      k_q      <= 4'd1;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) k_q <= cfg_wdata_i;
      if (mem_we) count_q <= count_q + 1'b1;
      if (accept && in_data_i.mode == ModeStart) count_q <= '0;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if ((state_q == StEmit || state_q == StFail) && (!ovalid_q || !out_stall_i))
        ovalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        n_q        <= count_q;
        kk_q       <= KW'(k_q);
        city_q     <= '0;
        total_q    <= '0;
        emit_q     <= '0;
        best_sum_q <= '1;
        for (int i = 0; i < MAX_SITES; i++) cur_q[i] <= AW'(i);
      end
      StCwait: begin
        cpos_q <= mem_rdata[15:0];
        cpop_q <= mem_rdata[31:16];
        j_q    <= '0;
      end
      StSwait: begin
        prev_q <= site_dist;
        if (j_q == '0 || site_dist < near_q) near_q <= site_dist;
        j_q <= j_q + 1'b1;
      end
      StAcc: prod_q <= cpop_q * near_q[15:0];
      StMul: total_q <= (tsum > (SumW+1)'(SumMax)) ? (SumW+1)'(SumMax) : tsum;
      StNext: begin
        if ((CW'(city_q) + 1'b1) == n_q) begin
          city_q  <= '0;
          total_q <= '0;
          if (total_q <= best_sum_q) begin
            best_sum_q <= total_q;
            for (int i = 0; i < MAX_SITES; i++) best_q[i] <= cur_q[i];
          end
          for (int i = 0; i < MAX_SITES; i++) cur_q[i] <= nxt[i];
        end else begin
          city_q <= city_q + 1'b1;
        end
      end
      StEmit: if (!ovalid_q || !out_stall_i) begin
        odata_q.site_index  <= 4'(best_q[emit_q]);
        odata_q.best_sum    <= best_sum_q[SumW-1:0];
        odata_q.no_solution <= 1'b0;
        odata_q.last        <= (KW'(emit_q) + 1'b1 == kk_q);
        emit_q <= emit_q + 1'b1;
      end
      StFail: if (!ovalid_q || !out_stall_i) begin
        odata_q.site_index  <= '0;
        odata_q.best_sum    <= '0;
        odata_q.no_solution <= 1'b1;
        odata_q.last        <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !accept) else $error("beat accepted while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_CITIES)) else $error("city count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> ovalid_q && $stable(odata_q))
    else $error("output beat lost under stall");

endmodule

### tb/tb_weighted_k_median_line_search.sv
module tb_weighted_k_median_line_search;
  import wkm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumCities = 16;
  localparam int unsigned NumSites  = 8;
  localparam longint unsigned CycleLimit = 64'd40_000_000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  wkm_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  wkm_out_t   out_data_o;

  weighted_k_median_line_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the block state.
  logic [15:0] pop_mem [NumCities];
  logic [15:0] pos_mem [NumCities];
  int unsigned loaded_cities = 0;
  logic [3:0]  k_sites = 4'd1;

  wkm_in_t  pending_beats [$];
  wkm_out_t expected_results [$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned searches_run = 0;
  longint unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_phase = 0;
  bit stall_mode = 1'b0;

  function automatic longint unsigned city_span(int unsigned a, int unsigned b);
    longint unsigned pa, pb;
    pa = pos_mem[a];
    pb = pos_mem[b];
    return (pa >= pb) ? pa - pb : pb - pa;
  endfunction

  function automatic longint unsigned subset_cost(int unsigned n, int unsigned k,
                                                   int unsigned sub [NumSites]);
    longint unsigned total, nearest, d;
    total = 0;
    for (int unsigned c = 0; c < n; c++) begin
      nearest = city_span(c, sub[0]);
      for (int unsigned j = 1; j < k; j++) begin
        d = city_span(c, sub[j]);
        if (d < nearest) nearest = d;
        // The scan stops once the distance starts to grow again.
        if (d > city_span(c, sub[j-1])) break;
      end
      total += longint'(pop_mem[c]) * nearest;
      if (total > longint'(SumMax)) total = SumMax;
    end
    return total;
  endfunction

  task automatic predict_beat(input wkm_in_t beat);
    int unsigned n, k, i;
    int unsigned sub [NumSites];
    int unsigned best [NumSites];
    longint unsigned best_cost, cost;
    bit more;
    wkm_out_t r;
    if (beat.mode == ModeLoad) begin
      if (loaded_cities < NumCities) begin
        pop_mem[loaded_cities] = beat.population;
        pos_mem[loaded_cities] = beat.position;
        loaded_cities++;
      end
      return;
    end
    n = loaded_cities;
    k = k_sites;
    loaded_cities = 0;
    searches_run++;
    if (k == 0 || k > NumSites || k > n) begin
      r = '0;
      r.no_solution = 1'b1;
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    best_cost = 64'h1F_FFFF_FFFF;
    for (int unsigned j = 0; j < NumSites; j++) begin
      sub[j] = j;
      best[j] = 0;
    end
    do begin
      cost = subset_cost(n, k, sub);
      if (cost <= best_cost) begin
        best_cost = cost;
        best = sub;
      end
      more = 1'b0;
      i = k;
      while (i > 0 && !more) begin
        i--;
        if (sub[i] < n - k + i) begin
          sub[i]++;
          for (int unsigned j = i + 1; j < k; j++) sub[j] = sub[j-1] + 1;
          more = 1'b1;
        end
      end
    end while (more);
    for (int unsigned j = 0; j < k; j++) begin
      r.site_index = best[j][3:0];
      r.best_sum = best_cost[SumW-1:0];
      r.no_solution = 1'b0;
      r.last = (j + 1 == k);
      expected_results.push_back(r);
    end
  endtask

  function automatic wkm_in_t load_beat(logic [15:0] pop, logic [15:0] pos);
    wkm_in_t b;
    b.mode = ModeLoad;
    b.population = pop;
    b.position = pos;
    return b;
  endfunction

  function automatic wkm_in_t start_beat();
    wkm_in_t b;
    b.mode = ModeStart;
    b.population = 16'($urandom);
    b.position = 16'($urandom);
    return b;
  endfunction

  // Queue a city set of n cities, mostly ascending positions, then a start.
  task automatic queue_search(int unsigned n, bit extreme);
    logic [15:0] pos;
    pos = 16'($urandom_range(0, 2000));
    for (int unsigned c = 0; c < n; c++) begin
      if (extreme) begin
        pending_beats.push_back(load_beat(16'hFFFF, (c % 2) ? 16'hFFFF : 16'h0000));
      end else if ($urandom_range(0, 5) == 0) begin
        pending_beats.push_back(load_beat(16'($urandom), 16'($urandom)));
      end else begin
        pos = pos + 16'($urandom_range(0, 8000));
        pending_beats.push_back(load_beat(16'($urandom), pos));
      end
    end
    pending_beats.push_back(start_beat());
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_k(logic [3:0] k);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_sites = k;
  endtask

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_beat(in_data_i);
        void'(pending_beats.pop_front());
      end
      if ((in_valid_i && in_stall_o)) begin
        // Hold the stalled beat.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else begin
        // Size no longer counts the beat just accepted, which is popped above.
        if (pending_beats.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_beats[0];
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk_i) begin
    wkm_out_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_data_o);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_o.site_index !== exp_r.site_index)
            $display("%0t: site_index expected %0d actual %0d", $time,
                     exp_r.site_index, out_data_o.site_index);
          if (out_data_o.best_sum !== exp_r.best_sum)
            $display("%0t: best_sum expected %0d actual %0d", $time,
                     exp_r.best_sum, out_data_o.best_sum);
          if (out_data_o.no_solution !== exp_r.no_solution)
            $display("%0t: no_solution expected %0b actual %0b", $time,
                     exp_r.no_solution, out_data_o.no_solution);
          if (out_data_o.last !== exp_r.last)
            $display("%0t: last expected %0b actual %0b", $time,
                     exp_r.last, out_data_o.last);
          if (out_data_o !== exp_r) fail_count++;
        end
      end
      if (stall_phase == 0) begin
        stall_phase <= $urandom_range(1, 10);
        stall_mode <= ($urandom_range(0, 3) == 0) ? 1'b0 : ~stall_mode;
      end else begin
        stall_phase <= stall_phase - 1;
      end
      out_stall_i <= stall_mode ? ($urandom_range(0, 1) == 1) : 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [3:0] k_list [6];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_k(4'd1);
    // Start with nothing loaded, then a single city.
    pending_beats.push_back(start_beat());
    pending_beats.push_back(load_beat(16'h0000, 16'h0000));
    pending_beats.push_back(start_beat());
    // Extreme weights and coordinates.
    queue_search(4, 1'b1);
    // Non-ascending positions.
    pending_beats.push_back(load_beat(16'd5, 16'd900));
    pending_beats.push_back(load_beat(16'd7, 16'd100));
    pending_beats.push_back(load_beat(16'd3, 16'd500));
    pending_beats.push_back(start_beat());
    wait_idle();
    // k of zero, k above the site limit, k above the city count.
    write_k(4'd0);
    queue_search(3, 1'b0);
    wait_idle();
    write_k(4'd15);
    queue_search(9, 1'b0);
    wait_idle();
    write_k(4'd3);
    queue_search(2, 1'b0);
    wait_idle();
    // Overfilled table: the extra loads are dropped.
    write_k(4'd8);
    for (int i = 0; i < 18; i++)
      pending_beats.push_back(load_beat(16'hFFFF, (i % 2) ? 16'hFFFF : 16'h0000));
    pending_beats.push_back(start_beat());
    wait_idle();
    // Random phases over several k settings.
    k_list = '{4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd9};
    foreach (k_list[p]) begin
      write_k(k_list[p]);
      for (int s = 0; s < ((k_list[p] >= 8) ? 1 : 2); s++) begin
        if (k_list[p] >= 8)
          queue_search($urandom_range(k_list[p], 10), 1'b0);
        else
          queue_search($urandom_range(k_list[p] > 1 ? k_list[p] - 1 : 1, 9), 1'b0);
      end
      wait_idle();
    end
    $display("Ran %0d searches with %0d result beats checked over k from 0 to 15.",
             searches_run, results_seen);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
